/* rtl/sliding_weighted_mean_unit_assert.svh */
// assertion macros for the sliding weighted mean unit
// included by the top level, no other dependencies
`ifndef SLIDING_WEIGHTED_MEAN_UNIT_ASSERT_SVH
`define SLIDING_WEIGHTED_MEAN_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SWM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swm: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SWM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swm: next-cycle check failed");

`endif

/* rtl/swm_pkg.sv */
// shared types and constants of the sliding weighted mean unit
// no dependencies
`default_nettype none

package swm_pkg;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int WEIGHT_W  = 16;
   localparam int PROD_W    = 32;
   localparam int MEAN_W    = 16;
   localparam int TOTAL_W   = 24;
   localparam int LEN_CFG_W = 9;

   // defaults
   localparam int WINDOW_MAX_DEF = 256;
   localparam int LEN_RESET      = 16;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_UPDATE = 6'b000100,
      S_SETUP  = 6'b001000,
      S_DIV    = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

endpackage

`default_nettype wire

/* rtl/swm_req_if.sv */
// input channel of the sliding weighted mean unit: sample, weight, restart
// depends on swm_pkg
`default_nettype none

interface swm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [swm_pkg::SAMPLE_W-1:0] sample;
   logic        [swm_pkg::WEIGHT_W-1:0] weight;
   logic                                restart;

   modport source (output valid, output sample, output weight, output restart, input ready);
   modport sink   (input valid, input sample, input weight, input restart, output ready);
endinterface

`default_nettype wire

/* rtl/swm_rsp_if.sv */
// result channel of the sliding weighted mean unit: mean, total weight, flag
// depends on swm_pkg
`default_nettype none

interface swm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [swm_pkg::MEAN_W-1:0]  mean;
   logic        [swm_pkg::TOTAL_W-1:0] total_weight;
   logic                               zero_weight;

   modport source (output valid, output mean, output total_weight, output zero_weight,
                   input ready);
   modport sink   (input valid, input mean, input total_weight, input zero_weight,
                   output ready);
endinterface

`default_nettype wire

/* rtl/swm_csr_if.sv */
// configuration write channel of the sliding weighted mean unit
// depends on swm_pkg
`default_nettype none

interface swm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [swm_pkg::LEN_CFG_W-1:0]        window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

/* rtl/swm_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire  logic                     clock,
   input  wire  logic                     wr_en,
   input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  logic [WIDTH-1:0]         wr_data,
   input  wire  logic                     rd_en,
   input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic       [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/sliding_weighted_mean_unit.sv */
// sliding weighted mean unit: top level with sequencer, accumulators, divider
// depends on swm_pkg, swm_req_if, swm_rsp_if, swm_csr_if, swm_ram and the assert header
//
// Usage:
//   req_bus carries one beat per item: a signed Q8.8 sample, an unsigned Q8.8
//   weight and a restart bit that clears the window before the item is used.
//   csr_bus writes window_length (0 acts as 1, values above WINDOW_MAX saturate);
//   a write also clears the window. Write it only while no item is in flight.
//   Once window_length items have arrived since a restart, each item gives one
//   rsp_bus beat: the weighted mean (truncated toward zero), the total weight
//   (saturating at 24 bits) and a zero_weight flag (mean is then 0).
// Steps:
//   An item without a result passes through accept, ring read and update.
//   An item with a result then goes on to divider setup, the divide and the
//   final step: the restoring divider resolves one quotient bit per cycle.
//   rsp_bus.valid rises once the final step loads the output register.
// Reset and stall:
//   Synchronous reset clears the sums, fill count, ring pointer and sets
//   window_length to min(16, WINDOW_MAX); the ring memories hold no reset.
//   A stalled rsp_bus holds its beat; the next item is accepted and worked
//   on meanwhile and waits in the final step until the output register is free.
`default_nettype none

`include "sliding_weighted_mean_unit_assert.svh"

module sliding_weighted_mean_unit #(
   parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   swm_req_if.sink    req_bus,
   swm_rsp_if.source  rsp_bus,
   swm_csr_if.sink    csr_bus
);

   import swm_pkg::*;

   // derived widths
   localparam int PTR_W   = $clog2(WINDOW_MAX);
   localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
   localparam int LX_W    = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
   localparam int AW      = LEN_W + 1;
   localparam int WSUM_W  = WEIGHT_W + PTR_W;
   localparam int WSUM_X  = (WSUM_W > TOTAL_W) ? WSUM_W : TOTAL_W;
   localparam int PSUM_W  = PROD_W + PTR_W + 1;
   localparam int DIV_W   = WSUM_W + MEAN_W - 1;
   localparam int CMP_W   = (PSUM_W > DIV_W) ? PSUM_W : DIV_W;
   localparam int CNT_W   = $clog2(MEAN_W);
   localparam int LEN_RST = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

   // registers and next values
   state_type                  state_ff, state_in;
   logic [LEN_W-1:0]           eff_len_ff, eff_len_in;
   logic [LEN_W-1:0]           fill_count_ff, fill_count_in;
   logic [PTR_W-1:0]           ptr_ff, ptr_in;
   logic signed [PSUM_W-1:0]   psum_ff, psum_in;
   logic [WSUM_W-1:0]          wsum_ff, wsum_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [WEIGHT_W-1:0]        weight_ff, weight_in;
   logic [PSUM_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]           div_ff, div_in;
   logic [MEAN_W-1:0]          quo_ff, quo_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       neg_ff, neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MEAN_W-1:0]   mean_ff, mean_in;
   logic [TOTAL_W-1:0]         total_ff, total_in;
   logic                       zero_ff, zero_in;

   // combinational helpers
   logic                       req_fire;
   logic                       csr_fire;
   logic [LX_W-1:0]            cfg_x;
   logic [LEN_W-1:0]           cfg_eff;
   logic [AW-1:0]              old_sum;
   logic [PTR_W-1:0]           old_addr;
   logic                       ring_we;
   logic                       ring_re;
   logic signed [PROD_W-1:0]   old_prod;
   logic [WEIGHT_W-1:0]        old_weight;
   logic                       full;
   logic [CMP_W-1:0]           rem_x;
   logic [CMP_W-1:0]           div_x;
   logic [WSUM_X-1:0]          wsum_x;
   logic signed [SAMPLE_W+WEIGHT_W:0] prod_full;
   logic                       done_load;

   // handshakes: configuration wins over an item in the same cycle
   assign csr_bus.ready = (state_ff == S_IDLE);
   assign req_bus.ready = (state_ff == S_IDLE) && !csr_bus.valid;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // effective window length from the written value
   assign cfg_x   = LX_W'(csr_bus.window_length);
   assign cfg_eff = (cfg_x == '0) ? LEN_W'(1) :
                    (cfg_x > LX_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX) : LEN_W'(cfg_x);

   // full-width product of the incoming beat
   assign prod_full = req_bus.sample * $signed({1'b0, req_bus.weight});

   // ring slot that leaves the window
   assign old_sum  = AW'(ptr_ff) + AW'(WINDOW_MAX) - AW'(eff_len_ff);
   assign old_addr = (old_sum >= AW'(WINDOW_MAX)) ? PTR_W'(old_sum - AW'(WINDOW_MAX))
                                                  : PTR_W'(old_sum);

   assign ring_re = (state_ff == S_READ);
   assign ring_we = (state_ff == S_UPDATE);
   assign full    = (fill_count_ff >= eff_len_ff);

   // ring memories: the read of an item always follows the previous item's write
   swm_ram #(.WIDTH(PROD_W), .DEPTH(WINDOW_MAX)) u_prod_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ptr_ff),
      .wr_data (prod_ff),
      .rd_en   (ring_re),
      .rd_addr (old_addr),
      .rd_data (old_prod)
   );

   swm_ram #(.WIDTH(WEIGHT_W), .DEPTH(WINDOW_MAX)) u_weight_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ptr_ff),
      .wr_data (weight_ff),
      .rd_en   (ring_re),
      .rd_addr (old_addr),
      .rd_data (old_weight)
   );

   assign rem_x  = CMP_W'(rem_ff);
   assign div_x  = CMP_W'(div_ff);
   assign wsum_x = WSUM_X'(wsum_ff);

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      eff_len_in    = eff_len_ff;
      fill_count_in = fill_count_ff;
      ptr_in        = ptr_ff;
      psum_in       = psum_ff;
      wsum_in       = wsum_ff;
      prod_in       = prod_ff;
      weight_in     = weight_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      mean_in       = mean_ff;
      total_in      = total_ff;
      zero_in       = zero_ff;

      case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               eff_len_in    = cfg_eff;
               psum_in       = '0;
               wsum_in       = '0;
               fill_count_in = '0;
            end else if (req_fire) begin
               prod_in   = prod_full[PROD_W-1:0];
               weight_in = req_bus.weight;
               if (req_bus.restart) begin
                  psum_in       = '0;
                  wsum_in       = '0;
                  fill_count_in = '0;
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            // retire the oldest entry once the window is full, add the new one
            psum_in = psum_ff - (full ? PSUM_W'(old_prod) : '0) + PSUM_W'(prod_ff);
            wsum_in = wsum_ff - (full ? WSUM_W'(old_weight) : '0) + WSUM_W'(weight_ff);
            fill_count_in = full ? eff_len_ff : LEN_W'(fill_count_ff + 1'b1);
            ptr_in = (ptr_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : PTR_W'(ptr_ff + 1'b1);
            state_in = (fill_count_in == eff_len_ff) ? S_SETUP : S_IDLE;
         end
         S_SETUP: begin
            // divide magnitudes, fix the sign at the end
            neg_in = psum_ff[PSUM_W-1];
            rem_in = psum_ff[PSUM_W-1] ? PSUM_W'(-psum_ff) : PSUM_W'(psum_ff);
            div_in = DIV_W'(wsum_ff) << (MEAN_W - 1);
            quo_in = '0;
            cnt_in = CNT_W'(MEAN_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            // one restoring step per cycle
            if (rem_x >= div_x) begin
               rem_in = PSUM_W'(rem_x - div_x);
               quo_in = {quo_ff[MEAN_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[MEAN_W-2:0], 1'b0};
            end
            div_in = div_ff >> 1;
            cnt_in = CNT_W'(cnt_ff - 1'b1);
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               zero_in      = (wsum_ff == '0);
               if (wsum_ff == '0) begin
                  mean_in  = '0;
                  total_in = '0;
               end else begin
                  mean_in  = neg_ff ? MEAN_W'(-quo_ff) : MEAN_W'(quo_ff);
                  total_in = (|(wsum_x >> TOTAL_W)) ? '1 : wsum_x[TOTAL_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         eff_len_ff    <= LEN_W'(LEN_RST);
         fill_count_ff <= '0;
         ptr_ff        <= '0;
         psum_ff       <= '0;
         wsum_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         eff_len_ff    <= eff_len_in;
         fill_count_ff <= fill_count_in;
         ptr_ff        <= ptr_in;
         psum_ff       <= psum_in;
         wsum_ff       <= wsum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      weight_ff <= weight_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      mean_ff   <= mean_in;
      total_ff  <= total_in;
      zero_ff   <= zero_in;
   end

   // result channel
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mean         = mean_ff;
   assign rsp_bus.total_weight = total_ff;
   assign rsp_bus.zero_weight  = zero_ff;

   // checks
   assign done_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   `SWM_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_count_ff <= eff_len_ff)
   `SWM_ASSERT_NEXT(a_accept_reads, clock, reset, req_fire, state_ff == S_READ)
   `SWM_ASSERT_NEXT(a_done_loads, clock, reset, done_load, rsp_valid_ff && state_ff == S_IDLE)

endmodule

`default_nettype wire
